// ===== hdl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg: shared types and codes of the ordered list
// Command opcodes, mode and status codes, sequencer states and the command
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int ID_WIDTH           = 32;
   localparam int DEFAULT_LIST_DEPTH = 64;
   localparam int QUEUE_DEPTH        = 2;

   // request mode codes
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_DRAIN  = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_DRAINED  = 2'd3;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_REMOVE,
      OP_DRAIN,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic signed [ID_WIDTH-1:0]  id;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_RESP,
      ST_DRAIN_RD,
      ST_DRAIN_EMIT
   } state_type;

endpackage

// ===== hdl/olist_front.sv =====
// ----------------------------------------------------------------------------
// olist_front: request intake and command queue
// Accepts requests, decodes the mode into a command and holds it in a short
// queue until the back end pops it.
// ----------------------------------------------------------------------------
module olist_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic signed [olist_pkg::ID_WIDTH-1:0] req_item_id,
   output logic                                 cmd_valid,
   output olist_pkg::cmd_type                   cmd,
   input  logic                                 cmd_pop
);

   localparam int QD  = olist_pkg::QUEUE_DEPTH;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);

   olist_pkg::cmd_type q_ff [QD];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] fill_ff, fill_in;
   olist_pkg::cmd_type dec_cmd;
   logic push;
   logic pop;

   assign req_stall = (fill_ff == QCW'(QD));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      dec_cmd.id = req_item_id;
      unique case (req_mode)
         olist_pkg::MODE_APPEND: dec_cmd.op = olist_pkg::OP_APPEND;
         olist_pkg::MODE_REMOVE: dec_cmd.op = olist_pkg::OP_REMOVE;
         olist_pkg::MODE_DRAIN:  dec_cmd.op = olist_pkg::OP_DRAIN;
         default:                dec_cmd.op = olist_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QD - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QD - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QCW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule

// ===== hdl/olist_back.sv =====
// ----------------------------------------------------------------------------
// olist_back: list store and command sequencer
// Holds the entries in a single-port-read memory, executes append, remove
// and drain commands one at a time and drives the response register.
// ----------------------------------------------------------------------------
module olist_back #(
   parameter int LIST_DEPTH = olist_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   input  olist_pkg::cmd_type                    cmd,
   output logic                                  cmd_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic signed [olist_pkg::ID_WIDTH-1:0] rsp_out_id,
   output logic                                  rsp_has_item,
   output logic                                  rsp_last
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int IW = olist_pkg::ID_WIDTH;

   logic [IW-1:0] entry_mem [LIST_DEPTH];

   olist_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          found_ff, found_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] key_ff, key_in;
   logic [1:0]    stat_ff, stat_in;
   logic [IW-1:0] rd_data_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [IW-1:0] rsp_id_ff, rsp_id_in;
   logic          rsp_has_ff, rsp_has_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [IW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   logic slot_free;
   logic list_full;
   logic scan_done;
   logic drain_last;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign list_full  = (count_ff == CW'(LIST_DEPTH));
   assign scan_done  = (ptr_ff >= count_ff) && !rd_pend_ff;
   assign drain_last = ((ptr_ff + CW'(1)) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         olist_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  olist_pkg::OP_REMOVE: state_in = olist_pkg::ST_REMOVE;
                  olist_pkg::OP_DRAIN:
                     state_in = (count_ff == '0) ? olist_pkg::ST_RESP
                                                 : olist_pkg::ST_DRAIN_RD;
                  default:              state_in = olist_pkg::ST_RESP;
               endcase
            end
         end
         olist_pkg::ST_REMOVE: begin
            if (scan_done) state_in = olist_pkg::ST_RESP;
         end
         olist_pkg::ST_RESP: begin
            if (slot_free) state_in = olist_pkg::ST_IDLE;
         end
         olist_pkg::ST_DRAIN_RD: begin
            state_in = olist_pkg::ST_DRAIN_EMIT;
         end
         olist_pkg::ST_DRAIN_EMIT: begin
            if (slot_free) begin
               state_in = drain_last ? olist_pkg::ST_IDLE : olist_pkg::ST_DRAIN_RD;
            end
         end
         default: state_in = olist_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      key_in        = key_ff;
      stat_in       = stat_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = cmd.id;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[AW-1:0];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         olist_pkg::ST_IDLE: begin
            rd_pend_in = 1'b0;
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               key_in   = cmd.id;
               ptr_in   = '0;
               found_in = 1'b0;
               stat_in  = olist_pkg::STAT_DONE;
               if (cmd.op == olist_pkg::OP_APPEND) begin
                  if (list_full) begin
                     stat_in = olist_pkg::STAT_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
         end
         olist_pkg::ST_REMOVE: begin
            // issue the next read while the previous one is compared
            if (ptr_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = ptr_ff[AW-1:0];
               ptr_in     = ptr_ff + CW'(1);
            end else begin
               rd_pend_in = 1'b0;
            end
            if (rd_pend_ff) begin
               if (found_ff) begin
                  // close the gap: move this entry down by one
                  mem_we  = 1'b1;
                  wr_addr = rd_idx_ff - AW'(1);
                  wr_data = rd_data_ff;
               end else if (rd_data_ff == key_ff) begin
                  found_in = 1'b1;
               end
            end
            if (scan_done) begin
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
                  stat_in  = olist_pkg::STAT_DONE;
               end else begin
                  stat_in  = olist_pkg::STAT_NOTFOUND;
               end
            end
         end
         olist_pkg::ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_id_in     = '0;
               rsp_has_in    = 1'b0;
               rsp_last_in   = 1'b1;
            end
         end
         olist_pkg::ST_DRAIN_RD: begin
            rd_en = 1'b1;
         end
         olist_pkg::ST_DRAIN_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = olist_pkg::STAT_DRAINED;
               rsp_id_in     = rd_data_ff;
               rsp_has_in    = 1'b1;
               rsp_last_in   = drain_last;
               ptr_in        = ptr_ff + CW'(1);
               if (drain_last) count_in = '0;
            end
         end
         default: begin
            rd_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olist_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      found_ff      <= found_in;
      rd_idx_ff     <= rd_idx_in;
      key_ff        <= key_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_id   = rsp_id_ff;
   assign rsp_has_item = rsp_has_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== hdl/ordered_list_delete_by_key.sv =====
// ----------------------------------------------------------------------------
// ordered_list_delete_by_key: ordered ID list with delete by value
// Keeps up to LIST_DEPTH IDs in arrival order. Mode 0 appends at the tail
// (status 1 when full), mode 1 removes the oldest equal entry and closes the
// gap (status 2 when absent), mode 2 drains every entry oldest first with
// last on the final one, or gives one empty marker for an empty list.
// Requests enter a two-entry command queue, so the request side keeps
// moving while a command runs. Commands execute one at a time against a
// memory with one read and one write port: a remove reads each stored
// entry once (the shift runs in the same pass), and a drain reads and
// then emits each entry in turn, set by the registered memory read. A
// response stall holds the sequencer until the response is taken.
// ----------------------------------------------------------------------------
module ordered_list_delete_by_key #(
   parameter int LIST_DEPTH = olist_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic signed [olist_pkg::ID_WIDTH-1:0] req_item_id,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic signed [olist_pkg::ID_WIDTH-1:0] rsp_out_id,
   output logic                                  rsp_has_item,
   output logic                                  rsp_last
);

   logic               cmd_valid;
   olist_pkg::cmd_type cmd;
   logic               cmd_pop;

   olist_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_item_id (req_item_id),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   olist_back #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_out_id   (rsp_out_id),
      .rsp_has_item (rsp_has_item),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hdl/olist_checker.sv =====
// ----------------------------------------------------------------------------
// olist_checker: port-level checks of the ordered list
// Watches the response channel and checks how status, item and last fit
// together.
// ----------------------------------------------------------------------------
module olist_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [1:0]                            rsp_status,
   input logic signed [olist_pkg::ID_WIDTH-1:0] rsp_out_id,
   input logic                                  rsp_has_item,
   input logic                                  rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_id) && $stable(rsp_has_item) && $stable(rsp_last))
      else $error("stalled response changed");

   a_item_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_item == (rsp_status == olist_pkg::STAT_DRAINED)))
      else $error("has_item does not match drained status");

   a_empty_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_item |-> rsp_out_id == '0)
      else $error("non-item response carries an id");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != olist_pkg::STAT_DRAINED) |-> rsp_last)
      else $error("single response without last");

endmodule

bind ordered_list_delete_by_key olist_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_out_id   (rsp_out_id),
   .rsp_has_item (rsp_has_item),
   .rsp_last     (rsp_last)
);
